// File: hdl/bitmap_run_allocator_assert.svh
// Assertion macros for the bitmap run allocator.
// Included by the top level; needs nothing else.
`ifndef BITMAP_RUN_ALLOCATOR_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge, ignored while reset is held.
`define BRA_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bitmap_run_allocator: assertion failed");
// Property checked on every clock edge, reset included.
`define BRA_ASSERT_ON(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bitmap_run_allocator: assertion failed");
`else
`define BRA_ASSERT_RST(lbl, clk, rstn, prop)
`define BRA_ASSERT_ON(lbl, clk, prop)
`endif

`endif

// File: hdl/bra_pkg.sv
// Shared types and constants of the bitmap run allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bra_pkg;

    // Field widths of the command and result words
    localparam int CMD_W  = 2;
    localparam int CNT_W  = 11;
    localparam int BLK_W  = 10;
    localparam int CFG_W  = 11;

    // Bitmap row geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Capacity register value after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [CNT_W-1:0] run_count;
        logic [BLK_W-1:0] start_block;
    } cmd_word_t;

    typedef struct packed {
        logic             ok;
        logic [BLK_W-1:0] granted_block;
        logic             double_free;
    } result_word_t;

endpackage

// File: hdl/bitmap_run_allocator.sv
// Top level of the bitmap run allocator: sequencer, hint and result stage.
// Depends on bra_pkg, bra_bitmap, bra_bit_scan and the assertion header.
//
//  channel  ports                       carries
//  -------  --------------------------  ------------------------------------
//  command  s_valid s_ready s_data      cmd_word_t: command, count, start
//  result   m_valid m_ready m_data      result_word_t: ok, granted, dbl free
//  config   cfg_valid cfg_ready cfg_data pool capacity, always ready
//
// One command at a time; the bitmap is kept as 32-bit rows in one memory.
// Allocate: a row read and a scan step per row, plus a step per run boundary
//   met, then a read and a write per row marked. Free: a read and a write per
//   row touched. Each command then hands over its result from the done state.
// Clear and reset: a pass that zeroes all ceil(MAX_BLOCKS/32) rows (32 by
//   default); no command is taken during the pass.
// A finished result waits in the output register; the next command is taken
//   meanwhile, and its result waits until the register is free.
`timescale 1ns / 1ps
`include "bitmap_run_allocator_assert.svh"

module bitmap_run_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bra_pkg::cmd_word_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bra_pkg::result_word_t        m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0]    cfg_data
);

    localparam int ROWS  = (MAX_BLOCKS + bra_pkg::WORD_W - 1) / bra_pkg::WORD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W = ($clog2(MAX_BLOCKS + 1) > bra_pkg::CFG_W) ?
                           $clog2(MAX_BLOCKS + 1) : bra_pkg::CFG_W;
    localparam int WW    = bra_pkg::WORD_W;
    localparam int BW    = bra_pkg::BIT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ARD   = 3'd2;
    localparam logic [2:0] ST_ASCAN = 3'd3;
    localparam logic [2:0] ST_MRD   = 3'd4;
    localparam logic [2:0] ST_MWR   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Mask of ones from bit lo up to bit hi inclusive
    function automatic logic [WW-1:0] span_mask(input logic [BW-1:0] lo,
                                                 input logic [BW-1:0] hi);
        logic [WW-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (BW'(WW - 1) - hi));
    endfunction

    logic [2:0]               state_reg;
    logic [bra_pkg::CFG_W-1:0] cfg_reg;
    logic [POS_W-1:0]         hint_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         start_reg;
    logic [POS_W-1:0]         run_reg;
    logic [POS_W-1:0]         rem_reg;
    logic                     skip_reg;
    logic                     set_reg;
    logic                     dbl_reg;
    logic                     res_ok_reg;
    logic [bra_pkg::BLK_W-1:0] res_grant_reg;
    logic                     clr_cmd_reg;
    logic [ROW_W-1:0]         clr_row_reg;
    logic                     m_valid_reg;
    bra_pkg::result_word_t    m_data_reg;

    logic [POS_W-1:0]         cap_eff;
    logic [POS_W-1:0]         cmd_n;
    logic [POS_W-1:0]         cmd_blk;
    logic [POS_W:0]           free_end;
    logic                     alloc_rej;
    logic                     free_rej;
    logic                     out_free;

    logic [WW-1:0]            rd_data;
    logic [BW:0]              hit_idx;
    logic [BW:0]              lim;
    logic [BW:0]              scan_end;
    logic [BW:0]              step;
    logic [POS_W-1:0]         pos_next;
    logic [POS_W-1:0]         run_sum;

    logic [BW:0]              room;
    logic [BW:0]              take;
    logic [BW-1:0]            hi_bit;
    logic [WW-1:0]            mask;
    logic [WW-1:0]            mark_word;
    logic [POS_W-1:0]         rem_next;

    logic                     wr_en;
    logic [ROW_W-1:0]         wr_addr;
    logic [WW-1:0]            wr_data;
    logic                     rd_en;
    logic [ROW_W-1:0]         pos_row;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Effective capacity: register limited to the pool size
    assign cap_eff = (POS_W'(cfg_reg) > POS_W'(MAX_BLOCKS)) ? POS_W'(MAX_BLOCKS)
                                                             : POS_W'(cfg_reg);

    // Reject checks on the incoming command
    assign cmd_n     = POS_W'(s_data.run_count);
    assign cmd_blk   = POS_W'(s_data.start_block);
    assign free_end  = {1'b0, cmd_blk} + {1'b0, cmd_n};
    assign alloc_rej = (cmd_n == '0) || (hint_reg >= cap_eff) ||
                       (cmd_n > (cap_eff - hint_reg));
    assign free_rej  = (cmd_n > cap_eff) || (cmd_blk >= cap_eff) ||
                       (free_end > {1'b0, cap_eff});

    assign pos_row = pos_reg[ROW_W+BW-1:BW];

    // Shared scan unit: next used bit when counting, next free bit when skipping
    bra_bit_scan u_scan (
        .word     (rd_data),
        .from_bit (pos_reg[BW-1:0]),
        .polarity (!skip_reg),
        .hit_idx  (hit_idx)
    );

    // Scan step arithmetic, limited to the pool end in the last row
    assign lim      = (pos_reg[POS_W-1:BW] == cap_eff[POS_W-1:BW]) ?
                      {1'b0, cap_eff[BW-1:0]} : (BW + 1)'(WW);
    assign scan_end = (hit_idx < lim) ? hit_idx : lim;
    assign step     = scan_end - {1'b0, pos_reg[BW-1:0]};
    assign pos_next = pos_reg + POS_W'(step);
    assign run_sum  = run_reg + POS_W'(step);

    // Row update for marking or freeing part of a run
    assign room      = (BW + 1)'(WW) - {1'b0, pos_reg[BW-1:0]};
    assign take      = (rem_reg >= POS_W'(room)) ? room : rem_reg[BW:0];
    assign hi_bit    = BW'(({1'b0, pos_reg[BW-1:0]} + take) - (BW + 1)'(1));
    assign mask      = span_mask(pos_reg[BW-1:0], hi_bit);
    assign mark_word = set_reg ? (rd_data | mask) : (rd_data & ~mask);
    assign rem_next  = rem_reg - POS_W'(take);

    // Memory port selection
    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_MWR);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_row_reg : pos_row;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : mark_word;
    assign rd_en   = (state_reg == ST_ARD) || (state_reg == ST_MRD);

    bra_bitmap #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (pos_row),
        .rd_data (rd_data)
    );

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bra_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            hint_reg    <= '0;
            clr_cmd_reg <= 1'b0;
            clr_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop the result word once taken
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_row_reg <= clr_row_reg + ROW_W'(1);
                    if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                        clr_row_reg <= '0;
                        state_reg   <= clr_cmd_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        res_ok_reg    <= 1'b0;
                        res_grant_reg <= '0;
                        dbl_reg       <= 1'b0;
                        rem_reg       <= cmd_n;
                        state_reg     <= ST_DONE;
                        case (s_data.command)
                            bra_pkg::CMD_ALLOC: begin
                                if (!alloc_rej) begin
                                    pos_reg   <= hint_reg;
                                    start_reg <= hint_reg;
                                    run_reg   <= '0;
                                    skip_reg  <= 1'b0;
                                    state_reg <= ST_ARD;
                                end
                            end
                            bra_pkg::CMD_FREE: begin
                                if (!free_rej) begin
                                    res_ok_reg <= 1'b1;
                                    set_reg    <= 1'b0;
                                    pos_reg    <= cmd_blk;
                                    if (cmd_blk < hint_reg) begin
                                        hint_reg <= cmd_blk;
                                    end
                                    if (cmd_n != '0) begin
                                        state_reg <= ST_MRD;
                                    end
                                end
                            end
                            bra_pkg::CMD_CLEAR: begin
                                res_ok_reg  <= 1'b1;
                                hint_reg    <= '0;
                                clr_cmd_reg <= 1'b1;
                                clr_row_reg <= '0;
                                state_reg   <= ST_CLEAR;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_ARD: begin
                    state_reg <= ST_ASCAN;
                end
                ST_ASCAN: begin
                    if (!skip_reg) begin
                        // Count free bits up to the next used bit
                        if (run_sum >= rem_reg) begin
                            res_ok_reg    <= 1'b1;
                            res_grant_reg <= start_reg[bra_pkg::BLK_W-1:0];
                            set_reg       <= 1'b1;
                            pos_reg       <= start_reg;
                            if (start_reg == hint_reg) begin
                                hint_reg <= hint_reg + rem_reg;
                            end
                            state_reg <= ST_MRD;
                        end else if (pos_next >= cap_eff) begin
                            state_reg <= ST_DONE;
                        end else if (scan_end == (BW + 1)'(WW)) begin
                            pos_reg   <= pos_next;
                            run_reg   <= run_sum;
                            state_reg <= ST_ARD;
                        end else begin
                            pos_reg  <= pos_next;
                            run_reg  <= '0;
                            skip_reg <= 1'b1;
                        end
                    end else begin
                        // Skip used bits; the run restarts after them
                        pos_reg   <= pos_next;
                        start_reg <= pos_next;
                        run_reg   <= '0;
                        skip_reg  <= 1'b0;
                        if (pos_next >= cap_eff) begin
                            state_reg <= ST_DONE;
                        end else if (scan_end == (BW + 1)'(WW)) begin
                            state_reg <= ST_ARD;
                        end
                    end
                end
                ST_MRD: begin
                    state_reg <= ST_MWR;
                end
                ST_MWR: begin
                    // Write back the row and advance along the run
                    if (!set_reg && ((~rd_data & mask) != '0)) begin
                        dbl_reg <= 1'b1;
                    end
                    rem_reg <= rem_next;
                    pos_reg <= pos_reg + POS_W'(take);
                    state_reg <= (rem_next == '0) ? ST_DONE : ST_MRD;
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.ok              <= res_ok_reg;
                        m_data_reg.granted_block   <= res_grant_reg;
                        m_data_reg.double_free     <= dbl_reg;
                        clr_cmd_reg                <= 1'b0;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `BRA_ASSERT_RST(a_scan_in_pool, aclk, aresetn, (state_reg == ST_ASCAN) |-> (pos_reg < cap_eff))
    `BRA_ASSERT_RST(a_dbl_free_only, aclk, aresetn, (m_valid && m_data.double_free) |-> (m_data.ok && (m_data.granted_block == '0)))
    `BRA_ASSERT_RST(a_result_from_done, aclk, aresetn, $rose(m_valid) |-> ($past(state_reg) == ST_DONE))
    `BRA_ASSERT_RST(a_hint_in_range, aclk, aresetn, (state_reg == ST_IDLE) |-> (hint_reg <= POS_W'(MAX_BLOCKS)))
    `BRA_ASSERT_ON(a_reset_quiet, aclk, !aresetn |=> (!m_valid && !s_ready))

endmodule

// File: hdl/bra_bit_scan.sv
// Shared scan unit: finds the first bit of a given value at or above a
// start position in one bitmap row. Depends on bra_pkg.
`timescale 1ns / 1ps

module bra_bit_scan (
    input  logic [bra_pkg::WORD_W-1:0] word,
    input  logic [bra_pkg::BIT_W-1:0]  from_bit,
    input  logic                       polarity,
    output logic [bra_pkg::BIT_W:0]    hit_idx
);

    // Priority-encode the lowest matching bit; WORD_W when none matches
    always_comb begin
        logic [bra_pkg::WORD_W-1:0] cand;
        cand    = (polarity ? word : ~word) & ({bra_pkg::WORD_W{1'b1}} << from_bit);
        hit_idx = (bra_pkg::BIT_W + 1)'(bra_pkg::WORD_W);
        for (int i = bra_pkg::WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit_idx = (bra_pkg::BIT_W + 1)'(i);
            end
        end
    end

endmodule

// File: hdl/bra_bitmap.sv
// Used-bit map store: one write port, one read port with registered data.
// Depends on bra_pkg for the row width.
`timescale 1ns / 1ps

module bra_bitmap #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 5
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ROW_W-1:0]           wr_addr,
    input  logic [bra_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ROW_W-1:0]           rd_addr,
    output logic [bra_pkg::WORD_W-1:0] rd_data
);

    logic [bra_pkg::WORD_W-1:0] mem [ROWS];
    logic [bra_pkg::WORD_W-1:0] rd_data_reg;

    // Write one row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one row; hold the data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
